>>> hdl/cti_pkg.sv
// ----------------------------------------------------------------------------
// cti_pkg: cubic trajectory interpolator definitions
// Widths, microcode word layout and the control program of the sequencer.
// ----------------------------------------------------------------------------
package cti_pkg;

  // axes and field widths
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int ANGLE_W   = 8;
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int OUT_W     = 16;
  localparam int IN_DATA_W = 56;
  localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;

  // datapath widths
  localparam int S_W       = DUR_W + 1;    // s in Q1.16, 1.0 included
  localparam int WFAC_W    = S_W + 1;      // 3*2^16 - 2*s
  localparam int DIFF_W    = ANGLE_W + 1;
  localparam int ACC_W     = 58;           // signed, holds start*2^48 + diff*h
  localparam int MUL_A_W   = 50;
  localparam int MUL_B_W   = 19;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CNT_W     = 5;
  localparam int PC_W      = 4;
  localparam int H_FRAC    = 48;
  localparam int OUT_LSB   = 40;

  // datapath operations
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_ELAP,
    OP_CHECK,
    OP_DIV,
    OP_SQ,
    OP_CUBE,
    OP_SCALE,
    OP_ADD,
    OP_OUT,
    OP_FIN
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_FIN,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  jmp;   // taken when cond holds
    logic [PC_W-1:0]  nxt;   // taken otherwise
  } ctrl_t;

  // program addresses
  localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] PC_ELAP  = 4'd1;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd3;
  localparam logic [PC_W-1:0] PC_SQ    = 4'd4;
  localparam logic [PC_W-1:0] PC_CUBE  = 4'd5;
  localparam logic [PC_W-1:0] PC_SCALE = 4'd6;
  localparam logic [PC_W-1:0] PC_ADD   = 4'd7;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd8;
  localparam logic [PC_W-1:0] PC_FIN   = 4'd9;

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_LOAD:  w = '{OP_LOAD,  COND_NO_IN,    PC_LOAD,  PC_ELAP};
      PC_ELAP:  w = '{OP_ELAP,  COND_NONE,     PC_LOAD,  PC_CHECK};
      PC_CHECK: w = '{OP_CHECK, COND_FIN,      PC_FIN,   PC_DIV};
      PC_DIV:   w = '{OP_DIV,   COND_CNT_NZ,   PC_DIV,   PC_SQ};
      PC_SQ:    w = '{OP_SQ,    COND_NONE,     PC_LOAD,  PC_CUBE};
      PC_CUBE:  w = '{OP_CUBE,  COND_NONE,     PC_LOAD,  PC_SCALE};
      PC_SCALE: w = '{OP_SCALE, COND_NONE,     PC_LOAD,  PC_ADD};
      PC_ADD:   w = '{OP_ADD,   COND_NONE,     PC_LOAD,  PC_OUT};
      PC_OUT:   w = '{OP_OUT,   COND_OUT_BUSY, PC_OUT,   PC_LOAD};
      PC_FIN:   w = '{OP_FIN,   COND_OUT_BUSY, PC_FIN,   PC_LOAD};
      default:  w = '{OP_LOAD,  COND_NONE,     PC_LOAD,  PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/cubic_trajectory_interpolator_top.sv
// ----------------------------------------------------------------------------
// cubic_trajectory_interpolator_top: per-axis cubic motion profile
// Tracks target changes per axis and blends start to target with 3s^2 - 2s^3.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid / tready       axis, start_angle, target_angle, now_ms
//  m_axis    out  tvalid / tready       angle_out (Q8.8)
//  cfg       in   cfg_valid / cfg_ready duration_ms
//
//  a blended result is formed by the restoring divider loop forming s, then
//  three passes through one shared 50x19 multiplier; a finished motion or
//  unknown axis skips the divider loop and the multiplier passes
//  one item at a time; the next item can be taken in the cycle after the result is
//  loaded, while that result still waits
//  a result stalled on m_axis holds the sequencer at its output step
//  reset clears the per-axis targets and start times, duration resets to 1000
// ----------------------------------------------------------------------------
module cubic_trajectory_interpolator_top
  import cti_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // axis[1:0], start_angle[9:2], target_angle[17:10], now_ms[49:18], zero pad
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // angle_out[15:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,
  // duration_ms[15:0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [DUR_W-1:0]     cfg_data_i
);

  // sequencer and control
  logic [PC_W-1:0]   pc_q, pc_d;
  ctrl_t             cw;
  logic              take;
  logic              in_fire;
  logic              fin;
  logic              out_busy;

  // per-axis state
  logic [ANGLE_W-1:0] last_target_q [NUM_AXES];
  logic [TIME_W-1:0]  start_time_q  [NUM_AXES];
  logic               in_axis_ok;
  logic               changed;
  logic [AXIS_W-1:0]  in_axis;
  logic [ANGLE_W-1:0] in_start;
  logic [ANGLE_W-1:0] in_target;
  logic [TIME_W-1:0]  in_now;
  logic [ANGLE_W-1:0] stored_target;

  // item registers
  logic [AXIS_W-1:0]  axis_q;
  logic               axis_ok_q;
  logic [ANGLE_W-1:0] start_q, target_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [TIME_W-1:0]  start_rd;
  logic [DUR_W-1:0]   dur_q;

  // divider and multiplier datapath
  logic [S_W-1:0]     rem_q, rem_d;
  logic [S_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               div_ge;
  logic [S_W-1:0]     div_sub;
  logic [WFAC_W-1:0]  wfac;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_data_q, out_data_d;

  // input field unpacking
  assign in_axis   = s_axis_tdata[1:0];
  assign in_start  = s_axis_tdata[9:2];
  assign in_target = s_axis_tdata[17:10];
  assign in_now    = s_axis_tdata[49:18];

  assign cw            = ucode(pc_q);
  assign s_axis_tready = (cw.op == OP_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_busy      = out_valid_q && !m_axis_tready;

  // target-change detection at accept
  assign in_axis_ok    = (32'(in_axis) < NUM_AXES);
  assign stored_target = in_axis_ok ? last_target_q[in_axis] : '0;
  assign changed       = in_axis_ok && (stored_target != in_target);

  // finished motion test
  assign start_rd  = axis_ok_q ? start_time_q[axis_q] : '0;
  assign elapsed_d = now_q - start_rd;
  assign fin = !axis_ok_q || (dur_q == '0) || (elapsed_q > {16'b0, dur_q});

  // restoring divide step
  assign div_ge  = (rem_q >= {1'b0, dur_q});
  assign div_sub = div_ge ? (rem_q - {1'b0, dur_q}) : rem_q;

  // blend factor and angle difference
  assign wfac = WFAC_W'(3 * 65536) - {quo_q, 1'b0};
  assign diff = $signed({1'b0, target_q}) - $signed({1'b0, start_q});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.op)
      OP_SQ: begin
        mul_a = $signed({{(MUL_A_W-S_W){1'b0}}, quo_q});
        mul_b = $signed({{(MUL_B_W-S_W){1'b0}}, quo_q});
      end
      OP_CUBE: begin
        mul_a = $signed({{(MUL_A_W-33){1'b0}}, acc_q[32:0]});
        mul_b = $signed({{(MUL_B_W-WFAC_W){1'b0}}, wfac});
      end
      OP_SCALE: begin
        mul_a = $signed({1'b0, acc_q[48:0]});
        mul_b = MUL_B_W'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // datapath next values
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    case (cw.op)
      OP_CHECK: begin
        rem_d = elapsed_q[S_W-1:0];
        quo_d = '0;
        cnt_d = CNT_W'(S_W - 1);
      end
      OP_DIV: begin
        quo_d = {quo_q[S_W-2:0], div_ge};
        rem_d = {div_sub[S_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end
      OP_SQ, OP_CUBE, OP_SCALE: begin
        acc_d = prod[ACC_W-1:0];
      end
      OP_ADD: begin
        acc_d = acc_q + $signed({2'b0, start_q, {H_FRAC{1'b0}}});
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  // output register next values
  always_comb begin
    out_valid_d = out_busy;
    out_data_d  = out_data_q;
    if (!out_busy && (cw.op == OP_OUT)) begin
      out_valid_d = 1'b1;
      out_data_d  = acc_q[OUT_LSB+OUT_W-1:OUT_LSB];
    end else if (!out_busy && (cw.op == OP_FIN)) begin
      out_valid_d = 1'b1;
      out_data_d  = {target_q, 8'b0};
    end
  end

  // jump logic
  always_comb begin
    case (cw.cond)
      COND_NONE:     take = 1'b0;
      COND_NO_IN:    take = !in_fire;
      COND_FIN:      take = fin;
      COND_CNT_NZ:   take = (cnt_q != '0);
      COND_OUT_BUSY: take = out_busy;
      default:       take = 1'b0;
    endcase
    pc_d = take ? cw.jmp : cw.nxt;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_LOAD;
      out_valid_q <= 1'b0;
      dur_q       <= DUR_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        last_target_q[i] <= '0;
        start_time_q[i]  <= '0;
      end
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        dur_q <= cfg_data_i;
      end
      if (in_fire && changed) begin
        last_target_q[in_axis] <= in_target;
        start_time_q[in_axis]  <= in_now;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      axis_q    <= in_axis;
      axis_ok_q <= in_axis_ok;
      start_q   <= in_start;
      target_q  <= in_target;
      now_q     <= in_now;
    end
    if (cw.op == OP_ELAP) begin
      elapsed_q <= elapsed_d;
    end
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> hdl/cti_checker.sv
// ----------------------------------------------------------------------------
// cti_checker: port-level checks for the trajectory interpolator
// Watches the stream and configuration ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module cti_checker
  import cti_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [IN_DATA_W-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [DUR_W-1:0]     cfg_data_i
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // no result can appear the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // a fresh result returns the block to taking input
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input not reopened after result");

endmodule

bind cubic_trajectory_interpolator_top cti_checker u_cti_checker (.*);
